// ----- rtl/core/control_block_free_list_allocator_defines.svh -----
// Assertion macros shared by the control block allocator RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef CONTROL_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define CONTROL_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define CBFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cbfl_pkg.sv -----
// Shared constants, codes and divider interface types for the
// control block allocator. No dependencies.
package cbfl_pkg;

  localparam int MAX_BLOCKS_DEF = 256;

  localparam int ADDR_W      = 32;
  localparam int BSIZE_W     = 13;
  localparam int PAGE_W      = 23;
  localparam int FUNC_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_TDATA_W = 56;

  localparam logic [ADDR_W-1:0]  POOL_BYTES  = 32'd4096;
  localparam logic [PAGE_W-1:0]  PAGE_BASE   = 23'h600000;
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 13'd16;

  // item function codes
  localparam logic [FUNC_W-1:0] FN_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NONE  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b1;

  typedef struct packed {
    logic               start;
    logic [ADDR_W-1:0]  dividend;
    logic [BSIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/cbfl_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module cbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/cbfl_div.sv -----
// Restoring divider for a 32-bit dividend, one quotient bit per cycle.
// Depends on cbfl_pkg and the allocator defines header.
`include "control_block_free_list_allocator_defines.svh"

module cbfl_div (
  input  logic               clk,
  input  logic               rst,
  input  cbfl_pkg::div_req_t req,
  output cbfl_pkg::div_rsp_t rsp
);

  import cbfl_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ADDR_W - 1);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [BSIZE_W-1:0] rem;
  logic [BSIZE_W-1:0] dsor;
  logic [ADDR_W-1:0]  quo;

  logic [BSIZE_W:0]   trial;
  logic               fits;

  assign trial = {rem, quo[ADDR_W-1]};
  assign fits  = trial >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem  <= '0;
      dsor <= req.divisor;
      quo  <= req.dividend;
    end else if (busy) begin
      rem <= fits ? BSIZE_W'(trial - {1'b0, dsor}) : trial[BSIZE_W-1:0];
      quo <= {quo[ADDR_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  `CBFL_ASSERT_NOW(a_div_done_after_busy, done, $past(busy), "divider done without a run")
  `CBFL_ASSERT_NOW(a_div_no_restart, req.start, !busy, "divider started while busy")

endmodule

// ----- rtl/core/control_block_free_list_allocator.sv -----
// Control block allocator top level: handshakes, sequencer, registers.
// Depends on cbfl_pkg, cbfl_ram, cbfl_div and the allocator defines header.
//
// Usage
//   Input items arrive on s_axis: tuser = func (0 init, 1 alloc, 2 free),
//   tdata = block_address (used by free only). Each item gives exactly one
//   result on m_axis: tuser = ok, tdata = granted_address, page_address.
//   Registers pool_base (index 0) and block_size (index 1) are written on
//   the cfg channel, which is always ready; write them only while idle.
// Sequence per item, one item in flight
//   alloc: one next-pointer RAM read, then the result.
//   free:  waits on the 32-step bit-serial divider that
//          turns the address offset into a block index.
//   init:  the divide for 4096 / block_size,
//          then a sweep that rewrites one next-pointer entry per cycle;
//          a zero block size skips the divide.
//   Unknown func, failed alloc, free with zero size: straight to the result, ok = 0.
// Reset
//   rst sets pool_base to 0 and block_size to 16 and starts the same chain
//   sweep as init, during which s_axis_tready is low. No result.
// Stalls
//   A finished result sits in the output register; the next item may be
//   accepted and worked on meanwhile, and waits in its last state until
//   m_axis_tready frees the register.
`include "control_block_free_list_allocator_defines.svh"

module control_block_free_list_allocator #(
  parameter int MAX_BLOCKS = cbfl_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cbfl_pkg::ADDR_W-1:0]         s_axis_tdata,  // [31:0] block_address
  input  logic [cbfl_pkg::FUNC_W-1:0]         s_axis_tuser,  // [1:0] func
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cbfl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [31:0] granted_address,
                                                             // [54:32] page_address, [55] 0
  output logic                                m_axis_tuser,  // [0] ok
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbfl_pkg::ADDR_W-1:0]         cfg_data
);

  import cbfl_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_BLOCKS - 1);
  localparam logic [ADDR_W-1:0] MAX_Q    = ADDR_W'(MAX_BLOCKS);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state;
  logic [IDX_W-1:0]   sweep_cnt;
  logic               sweep_reply;   // sweep came from an init item
  logic [FUNC_W-1:0]  cur_func;
  logic [IDX_W-1:0]   top_index;
  logic [IDX_W-1:0]   sentinel_index;
  logic [ADDR_W-1:0]  pool_base;
  logic [BSIZE_W-1:0] block_size;

  logic               res_ok;
  logic [ADDR_W-1:0]  res_granted;
  logic [PAGE_W-1:0]  res_page;

  logic               accept;
  logic               out_free;
  logic               bs_zero;
  logic               q_in_range;
  logic [IDX_W-1:0]   q_idx;
  logic [IDX_W-1:0]   init_sentinel;
  logic [IDX_W+BSIZE_W-1:0] blk_offset;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]   mem_rdata;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready     = 1'b1;
  assign bs_zero       = (block_size == '0);

  // divider: free offset / block_size, or pool bytes / block_size for init
  assign div_req.start    = accept && !bs_zero &&
                            (s_axis_tuser == FN_FREE || s_axis_tuser == FN_INIT);
  assign div_req.dividend = (s_axis_tuser == FN_INIT) ? POOL_BYTES
                                                      : s_axis_tdata - pool_base;
  assign div_req.divisor  = block_size;

  assign q_in_range = div_rsp.quotient < MAX_Q;
  assign q_idx      = div_rsp.quotient[IDX_W-1:0];

  // N = 4096 / block_size, capped to MAX_BLOCKS and raised to 1
  always_comb begin
    if (!q_in_range) begin
      init_sentinel = LAST_IDX;
    end else if (div_rsp.quotient == '0) begin
      init_sentinel = '0;
    end else begin
      init_sentinel = q_idx - 1'b1;
    end
  end

  // block offset of the current top, for the granted address
  assign blk_offset = {{BSIZE_W{1'b0}}, top_index} * {{IDX_W{1'b0}}, block_size};

  // next-pointer RAM writes: chain sweep, or a push on free
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_cnt;
    mem_wdata = (sweep_cnt == LAST_IDX) ? '0 : sweep_cnt + 1'b1;
    if (state == S_SWEEP) begin
      mem_we = 1'b1;
    end else if (state == S_DIV && div_rsp.done && cur_func == FN_FREE && q_in_range) begin
      mem_we    = 1'b1;
      mem_waddr = q_idx;
      mem_wdata = top_index;
    end
  end

  cbfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_next_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (top_index),
    .rdata (mem_rdata)
  );

  cbfl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      block_size <= BSIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POOL_BASE:  pool_base  <= cfg_data;
        CFG_BLOCK_SIZE: block_size <= cfg_data[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_SWEEP;
      sweep_cnt      <= '0;
      sweep_reply    <= 1'b0;
      top_index      <= '0;
      sentinel_index <= LAST_IDX;
      cur_func       <= FN_NONE;
    end else begin
      unique case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == LAST_IDX) begin
            sweep_cnt <= '0;
            state     <= sweep_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur_func <= s_axis_tuser;
            unique case (s_axis_tuser)
              FN_INIT: begin
                if (bs_zero) begin
                  sentinel_index <= LAST_IDX;
                  top_index      <= '0;
                  sweep_reply    <= 1'b1;
                  state          <= S_SWEEP;
                end else begin
                  state <= S_DIV;
                end
              end
              FN_ALLOC: state <= (top_index == sentinel_index) ? S_DONE : S_ALLOC;
              FN_FREE:  state <= bs_zero ? S_DONE : S_DIV;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_ALLOC: begin
          top_index <= mem_rdata;   // pop
          state     <= S_DONE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (cur_func == FN_INIT) begin
              sentinel_index <= init_sentinel;
              top_index      <= '0;
              sweep_reply    <= 1'b1;
              state          <= S_SWEEP;
            end else begin
              if (q_in_range) begin
                top_index <= q_idx;   // push
              end
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result staging, no reset
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        res_ok      <= 1'b0;
        res_granted <= '0;
        res_page    <= '0;
      end
      S_ALLOC: begin
        res_ok      <= 1'b1;
        res_granted <= pool_base + ADDR_W'(blk_offset);
        res_page    <= PAGE_BASE + PAGE_W'({top_index, 12'h000});
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_ok <= (cur_func == FN_INIT) || q_in_range;
        end
      end
      S_SWEEP: begin
        res_ok <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tuser <= res_ok;
      m_axis_tdata <= {1'b0, res_page, res_granted};
    end
  end

  `CBFL_ASSERT_NEXT(a_one_in_flight, accept, !s_axis_tready, "item accepted while busy")
  `CBFL_ASSERT_NOW(a_idle_div_quiet, s_axis_tready, !div_rsp.busy, "ready while dividing")
  `CBFL_ASSERT_NEXT(a_done_loads_out, state == S_DONE && out_free, m_axis_tvalid, "result lost")
  `CBFL_ASSERT_NOW(a_empty_alloc, state == S_DONE && cur_func == FN_ALLOC && !res_ok,
    top_index == sentinel_index, "failed alloc with free blocks left")

endmodule

// ----- sim/tb.sv -----
// Testbench for control_block_free_list_allocator: drives allocate, free, rebuild
// and unused-code items, predicts every result and checks it. Depends on cbfl_pkg and the allocator.
`timescale 1ns / 1ps

module tb;
  import cbfl_pkg::*;

  localparam int BLOCKS      = MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int TAIL_CYCLES = 300;          // one rebuild: divide plus sweep

  // one result item as the block reports it
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] granted;
    logic [PAGE_W-1:0] page;
  } grant_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [ADDR_W-1:0]      s_axis_tdata;   // [31:0] block_address
  logic [FUNC_W-1:0]      s_axis_tuser;   // [1:0] func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] granted_address, [54:32] page_address
  logic                   m_axis_tuser;   // [0] ok
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [ADDR_W-1:0]      cfg_data;

  control_block_free_list_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mirror of the allocator: free stack links, top, end marker, registers.
  logic [7:0]         free_next [BLOCKS];
  logic [7:0]         free_top;
  logic [7:0]         end_index;
  logic [ADDR_W-1:0]  model_pool;
  logic [BSIZE_W-1:0] model_bsize;

  grant_t            awaited_grants [$];   // predicted results, oldest first
  logic [ADDR_W-1:0] live_blocks [$];      // addresses handed out and not yet freed
  grant_t            head_grant;
  int                errors;
  int                cycle_count;
  int                send_idle_pct;
  int                recv_stall_pct;

  function automatic void rebuild_chain(input logic [31:0] count);
    for (int i = 0; i < BLOCKS; i++)
      free_next[i] = (i + 1 < BLOCKS) ? 8'(i + 1) : 8'd0;
    free_top  = 8'd0;
    end_index = 8'(count - 1);
  endfunction

  // Work out the result of one item and advance the mirrored state.
  function automatic grant_t predict_grant(input logic [FUNC_W-1:0] fn,
                                           input logic [ADDR_W-1:0] addr);
    grant_t      g;
    logic [31:0] n;
    logic [31:0] idx;
    g = '0;
    case (fn)
      FN_INIT: begin
        // zero size means a full pool; oversize blocks leave only the end marker
        n = (model_bsize == 0) ? BLOCKS : POOL_BYTES / {19'd0, model_bsize};
        if (n > BLOCKS) n = BLOCKS;
        if (n < 1) n = 1;
        rebuild_chain(n);
        g.ok = 1'b1;
      end
      FN_ALLOC: begin
        if (free_top != end_index) begin
          g.granted = model_pool + {24'd0, free_top} * {19'd0, model_bsize};
          g.page    = PAGE_BASE + {3'd0, free_top, 12'd0};
          free_top  = free_next[free_top];
          g.ok      = 1'b1;
        end
      end
      FN_FREE: begin
        // no alignment or double free check: whatever in-range index divides out is pushed
        if (model_bsize != 0) begin
          idx = (addr - model_pool) / {19'd0, model_bsize};
          if (idx < BLOCKS) begin
            free_next[idx[7:0]] = free_top;
            free_top            = idx[7:0];
            g.ok                = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  // Receiver: random stalls, changed at the falling edge.
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_grants.size() == 0) begin
        $display("%0t: unexpected result item, tuser %b tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        head_grant = awaited_grants.pop_front();
        if (m_axis_tuser !== head_grant.ok) begin
          $display("%0t: ok expected %b actual %b", $time, head_grant.ok, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[31:0] !== head_grant.granted) begin
          $display("%0t: granted_address expected %h actual %h",
                   $time, head_grant.granted, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[54:32] !== head_grant.page) begin
          $display("%0t: page_address expected %h actual %h",
                   $time, head_grant.page, m_axis_tdata[54:32]);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one item; the prediction is taken at the accepting edge.
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] addr);
    grant_t g;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = fn;
    s_axis_tdata  = addr;
    do @(posedge clk); while (!s_axis_tready);
    g = predict_grant(fn, addr);
    awaited_grants.push_back(g);
    if (fn == FN_INIT) live_blocks.delete();
    if (fn == FN_ALLOC && g.ok) live_blocks.push_back(g.granted);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_quiet();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (awaited_grants.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ADDR_W-1:0] value);
    wait_quiet();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POOL_BASE) model_pool = value;
    else model_bsize = value[BSIZE_W-1:0];
    live_blocks.delete();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_pool(input logic [ADDR_W-1:0] pool, input logic [BSIZE_W-1:0] bsize);
    write_register(CFG_POOL_BASE, pool);
    write_register(CFG_BLOCK_SIZE, {19'd0, bsize});
  endtask

  // Reset chain of 256 blocks with base 0, size 16
  task automatic test_reset_state();
    send_item(FN_ALLOC, $urandom);
    send_item(FN_FREE, 32'h0000_000F);      // misaligned, still block 0
    send_item(FN_NONE, 32'hFFFF_FFFF);      // unused code
    send_item(FN_FREE, 32'hFFFF_FFFF);      // index far past the pool
  endtask

  // Largest legal size: one block, the end marker, so the stack starts empty
  task automatic test_single_block_pool();
    set_pool(32'hFFFF_FFFF, 13'd4096);
    send_item(FN_INIT, 32'h0);
    send_item(FN_ALLOC, 32'h0);
    send_item(FN_FREE, 32'h0000_2FFF);      // offset wraps to block 3
    send_item(FN_ALLOC, 32'h0);             // granted address wraps too
    send_item(FN_ALLOC, 32'h0);
  endtask

  task automatic test_zero_block_size();
    set_pool(32'h0000_1000, 13'd0);
    send_item(FN_FREE, 32'h0000_1000);      // rejected, no divide by zero
    send_item(FN_INIT, 32'h0);              // full chain
    send_item(FN_ALLOC, 32'h0);
  endtask

  task automatic test_oversize_block();
    set_pool(32'h1234_5678, 13'h1FFF);
    send_item(FN_INIT, 32'h0);              // count rounds up to one
    send_item(FN_ALLOC, 32'h0);
    send_item(FN_FREE, 32'h1234_5678 + 32'd255 * 32'h1FFF);
    send_item(FN_ALLOC, 32'h0);
  endtask

  task automatic test_end_marker_push();
    set_pool(32'h0, 13'd1);
    send_item(FN_INIT, 32'h0);
    send_item(FN_FREE, 32'd255);            // pushes the end block: stack reads empty
    send_item(FN_ALLOC, 32'h0);
    send_item(FN_FREE, 32'd256);            // just past the last index
  endtask

  task automatic test_double_free();
    set_pool(32'h8000_0000, 13'd2048);
    send_item(FN_INIT, 32'h0);              // two blocks, one usable
    send_item(FN_ALLOC, 32'h0);
    send_item(FN_ALLOC, 32'h0);
    send_item(FN_FREE, 32'h8000_0000);
    send_item(FN_FREE, 32'h8000_0000);      // block links to itself
    send_item(FN_ALLOC, 32'h0);
  endtask

  // Mostly alloc/free pairs on live addresses, with rebuilds and noise mixed in.
  task automatic test_random_traffic(input int count, input int send_pct,
                                     input int stall_pct, input logic [ADDR_W-1:0] pool,
                                     input logic [BSIZE_W-1:0] bsize);
    int          pick;
    int          k;
    logic [31:0] blk;
    logic [31:0] addr;
    set_pool(pool, bsize);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    send_item(FN_INIT, $urandom);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      blk  = $urandom_range(0, BLOCKS - 1);
      if (pick < 3) begin
        send_item(FN_INIT, $urandom);
      end else if (pick < 5) begin
        send_item(FN_NONE, $urandom);
      end else if (pick < 48 || (pick < 78 && live_blocks.size() == 0)) begin
        send_item(FN_ALLOC, $urandom);
      end else if (pick < 78) begin
        k    = $urandom_range(0, live_blocks.size() - 1);
        addr = live_blocks[k];
        if ($urandom_range(0, 4) != 0) live_blocks.delete(k);   // else a later double free
        send_item(FN_FREE, addr);
      end else if (pick < 88) begin
        send_item(FN_FREE, model_pool + blk * {19'd0, model_bsize});
      end else if (pick < 94) begin
        addr = model_pool + blk * {19'd0, model_bsize} + $urandom_range(1, model_bsize - 1);
        send_item(FN_FREE, addr);
      end else begin
        send_item(FN_FREE, $urandom);
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = FN_INIT;
    m_axis_tready  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_POOL_BASE;
    cfg_data       = '0;
    errors         = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    model_pool     = '0;
    model_bsize    = BSIZE_RESET;
    rebuild_chain(BLOCKS);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_single_block_pool();
    test_zero_block_size();
    test_oversize_block();
    test_end_marker_push();
    test_double_free();

    // four random traffic phases, each with its own pool setting
    test_random_traffic(306, 0, 0, 32'h0, 13'd16);
    test_random_traffic(306, 53, 0, 32'hFFFF_FFFF, 13'd256);
    test_random_traffic(306, 0, 53, $urandom, 13'($urandom_range(16, 4096)));
    test_random_traffic(306, 10, 10, 32'h7FFF_F000, 13'd1024);

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/cbfl_pkg.sv
rtl/core/cbfl_ram.sv
rtl/core/cbfl_div.sv
rtl/core/control_block_free_list_allocator.sv
sim/tb.sv
